// File: hw/rtl/ethhp_pkg.sv
// Shared types, constants and helpers for the Ethernet/VLAN/IP/L4 header parser.
package ethhp_pkg;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_VLAN     = 3'd2;
    localparam logic [2:0] ST_NOIP     = 3'd3;
    localparam logic [2:0] ST_PROTO    = 3'd4;
    localparam logic [2:0] ST_L4_SHORT = 3'd5;

    // EtherTypes
    localparam logic [15:0] ET_VLAN   = 16'h8100;
    localparam logic [15:0] ET_QINQ   = 16'h88A8;
    localparam logic [15:0] ET_QINQ_9 = 16'h9100;
    localparam logic [15:0] ET_IPV4   = 16'h0800;
    localparam logic [15:0] ET_IPV6   = 16'h86DD;

    localparam logic [3:0] IHL_MASK = 4'hF;

    // Header geometry
    localparam int ETH_LEN      = 14;
    localparam int TAG_LEN      = 4;
    localparam int IPV4_MIN_LEN = 20;
    localparam int IPV6_LEN     = 40;
    localparam int TCP_LEN      = 20;
    localparam int UDP_LEN      = 8;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // Header bytes kept: only offsets 12..31 are ever looked at
    localparam int HDR_LO    = 12;
    localparam int HDR_HI    = 31;
    localparam int HDR_IDX_W = 5;

    // Frame length as carried between front and back
    localparam int FLEN_W = 16;
    // Reported length fields
    localparam int LEN_W  = 14;
    localparam int OFF_W  = 7;

    // Descriptor queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    localparam int RES_W  = 73;
    localparam int DATA_W = 80;

    // Front-end classification of one finished frame
    typedef struct packed {
        logic [FLEN_W-1:0] len;
        logic [2:0]        early_status; // ST_OK, ST_SHORT, ST_VLAN or ST_NOIP
        logic [1:0]        tags;
        logic              ipv6;
        logic [3:0]        ihl_nib;
        logic [7:0]        proto;
    } desc_t;

    // Result word; last member lands in the lowest bits
    typedef struct packed {
        logic [LEN_W-1:0] frame_len;
        logic [LEN_W-1:0] pay_len;
        logic [OFF_W-1:0] payload_offset;
        logic [OFF_W-1:0] l4_off;
        logic [4:0]       l4_hlen;
        logic [7:0]       l4_proto;
        logic [5:0]       ip_hlen;
        logic [2:0]       ip_ver;
        logic [4:0]       eth_hlen;
        logic [2:0]       status;
        logic             valid_res;
    } res_t;

    function automatic logic is_tag(input logic [15:0] et);
        return (et == ET_VLAN) || (et == ET_QINQ) || (et == ET_QINQ_9);
    endfunction

endpackage

// File: hw/rtl/eth_vlan_ip_l4_header_parser.sv
// Top level of the Ethernet/VLAN/IP/L4 header parser.
//
//   Channel   Direction  Contents
//   s_*       in         frame word (tdata[7:0]), end of frame (tlast)
//   m_*       out        one header summary per frame (tdata[72:0])
//   cfg_*     in         L4 protocol filter, 8 bits, 0 accepts any
//
// One byte per cycle, sustained; s_tready drops only when the 4-entry
// descriptor queue is full. The summary of a frame passes through the queue
// and the output register, and is held there while m_tready is low. Reset
// (aresetn low, synchronous) clears the byte count, the queue, the output
// valid flag and the filter; the header byte store and output data have no reset.
module eth_vlan_ip_l4_header_parser import ethhp_pkg::*; #(
    parameter int MAX_FRAME_LEN = 16383
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] frame_byte
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    // [0] valid_res, [3:1] status, [8:4] eth_hlen, [11:9] ip_ver,
    // [17:12] ip_hlen, [25:18] l4_proto, [30:26] l4_hlen,
    // [37:31] l4_off, [44:38] payload_offset, [58:45] pay_len,
    // [72:59] frame_len, [79:73] zero
    output logic [DATA_W-1:0] m_tdata,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data
);

    logic  q_full;
    logic  push;
    desc_t push_desc;
    logic  q_valid;
    desc_t q_data;
    logic  q_pop;

    assign s_tready = !q_full;

    ethhp_front #(
        .MAX_FRAME_LEN(MAX_FRAME_LEN)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .byte_acc (s_tvalid && s_tready),
        .byte_data(s_tdata),
        .byte_last(s_tlast),
        .push     (push),
        .desc     (push_desc)
    );

    ethhp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (push),
        .wr_data (push_desc),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_valid(q_valid),
        .rd_data (q_data)
    );

    ethhp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// File: hw/rtl/ethhp_front.sv
// Front end: counts frame bytes, keeps header bytes and classifies the frame at its last word.
module ethhp_front import ethhp_pkg::*; #(
    parameter int MAX_FRAME_LEN = 16383
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_acc,
    input  logic [7:0] byte_data,
    input  logic       byte_last,
    output logic       push,
    output desc_t      desc
);

    localparam int CNT_W = $clog2(MAX_FRAME_LEN + 1);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  count_inc;
    logic [7:0]        hdr_reg [HDR_LO:HDR_HI];
    logic [7:0]        hdr_cur [HDR_LO:HDR_HI];
    logic              in_window;
    logic [FLEN_W-1:0] len;

    assign in_window = (count_reg >= CNT_W'(HDR_LO)) && (count_reg <= CNT_W'(HDR_HI));

    // hold at the ceiling on long frames
    assign count_inc = (count_reg == CNT_W'(MAX_FRAME_LEN)) ? count_reg
                                                             : count_reg + 1'b1;
    assign len = FLEN_W'(count_inc);

    always_comb begin
        count_next = count_reg;
        if (byte_acc) begin
            count_next = byte_last ? '0 : count_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_acc && in_window) begin
            hdr_reg[count_reg[HDR_IDX_W-1:0]] <= byte_data;
        end
    end

    // forward the word being accepted so the last word is visible to the decode
    always_comb begin
        for (int i = HDR_LO; i <= HDR_HI; i++) begin
            hdr_cur[i] = (byte_acc && count_reg == CNT_W'(i)) ? byte_data : hdr_reg[i];
        end
    end

    always_comb begin
        logic [15:0]      et0;
        logic [15:0]      et1;
        logic [15:0]      et2;
        logic [15:0]      et;
        logic [1:0]       tags;
        logic [2:0]       early;
        logic [OFF_W-1:0] eth;
        logic [3:0]       nib;
        logic [7:0]       p4;
        logic [7:0]       p6;
        et0   = {hdr_cur[12], hdr_cur[13]};
        et1   = {hdr_cur[16], hdr_cur[17]};
        et2   = {hdr_cur[20], hdr_cur[21]};
        tags  = 2'd0;
        et    = et0;
        early = ST_OK;
        if (len < FLEN_W'(ETH_LEN)) begin
            early = ST_SHORT;
        end else if (is_tag(et0)) begin
            if (len < FLEN_W'(ETH_LEN + TAG_LEN)) begin
                early = ST_VLAN;
            end else if (is_tag(et1)) begin
                if (len < FLEN_W'(ETH_LEN + 2 * TAG_LEN)) begin
                    early = ST_VLAN;
                end else begin
                    tags = 2'd2;
                    et   = et2;
                end
            end else begin
                tags = 2'd1;
                et   = et1;
            end
        end
        case (tags)
            2'd1: begin
                nib = hdr_cur[18][3:0];
                p4  = hdr_cur[27];
                p6  = hdr_cur[24];
            end
            2'd2: begin
                nib = hdr_cur[22][3:0];
                p4  = hdr_cur[31];
                p6  = hdr_cur[28];
            end
            default: begin
                nib = hdr_cur[14][3:0];
                p4  = hdr_cur[23];
                p6  = hdr_cur[20];
            end
        endcase
        eth = OFF_W'(ETH_LEN) + OFF_W'({tags, 2'b00});

        desc.len          = len;
        desc.tags         = 2'd0;
        desc.ipv6         = 1'b0;
        desc.ihl_nib      = '0;
        desc.proto        = '0;
        desc.early_status = early;
        if (early == ST_OK) begin
            desc.tags = tags;
            if (et == ET_IPV4 && len >= FLEN_W'(eth) + FLEN_W'(IPV4_MIN_LEN)) begin
                desc.ihl_nib = nib & IHL_MASK;
                desc.proto   = p4;
            end else if (et == ET_IPV6 && len >= FLEN_W'(eth) + FLEN_W'(IPV6_LEN)) begin
                desc.ipv6  = 1'b1;
                desc.proto = p6;
            end else begin
                desc.early_status = ST_NOIP;
            end
        end
    end

    assign push = byte_acc && byte_last;

endmodule

// File: hw/rtl/ethhp_queue.sv
// Short descriptor queue between the front end and the back end.
module ethhp_queue import ethhp_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  wr_en,
    input  desc_t wr_data,
    output logic  full,
    input  logic  rd_en,
    output logic  rd_valid,
    output desc_t rd_data
);

    desc_t              mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] cnt_reg;
    logic               do_wr;
    logic               do_rd;

    assign full     = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_wr, do_rd})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

// File: hw/rtl/ethhp_back.sv
// Back end: IP/L4 checks, offsets and the registered result word.
module ethhp_back import ethhp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data,
    input  logic              q_valid,
    input  desc_t             q_data,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata
);

    logic [7:0] filter_reg;
    logic       m_valid_reg;
    res_t       m_res_reg;
    res_t       res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_reg <= '0;
        end else if (cfg_wr_en) begin
            filter_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        logic [OFF_W-1:0] eth;
        logic [5:0]       ihl;
        logic [OFF_W-1:0] l4off;
        logic [4:0]       l4len;
        logic [OFF_W-1:0] poff;
        eth   = OFF_W'(ETH_LEN) + OFF_W'({q_data.tags, 2'b00});
        ihl   = q_data.ipv6 ? 6'(IPV6_LEN) : {q_data.ihl_nib, 2'b00};
        l4off = eth + OFF_W'(ihl);
        l4len = '0;
        poff  = '0;

        res                = '0;
        res.frame_len      = LEN_W'(q_data.len);
        res.status         = q_data.early_status;
        if (q_data.early_status == ST_NOIP) begin
            res.eth_hlen = 5'(eth);
        end else if (q_data.early_status == ST_OK) begin
            res.eth_hlen = 5'(eth);
            res.ip_ver   = q_data.ipv6 ? 3'd6 : 3'd4;
            res.ip_hlen  = ihl;
            res.l4_proto = q_data.proto;
            if (!q_data.ipv6 && q_data.len < FLEN_W'(l4off)) begin
                res.status = ST_NOIP;
            end else if (filter_reg != '0 && q_data.proto != filter_reg) begin
                res.status = ST_PROTO;
            end else begin
                res.l4_off = l4off;
                if (q_data.proto == PROTO_TCP) begin
                    l4len = 5'(TCP_LEN);
                end else if (q_data.proto == PROTO_UDP) begin
                    l4len = 5'(UDP_LEN);
                end
                poff = l4off + OFF_W'(l4len);
                if (q_data.len < FLEN_W'(poff)) begin
                    res.status = ST_L4_SHORT;
                end else begin
                    res.l4_hlen        = l4len;
                    res.payload_offset = poff;
                    res.pay_len        = LEN_W'(q_data.len - FLEN_W'(poff));
                end
            end
        end
        res.valid_res = (res.status == ST_OK);
    end

    // advance when the output word is empty or being taken
    assign q_pop = q_valid && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (q_pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(DATA_W - RES_W)'(0), m_res_reg};

endmodule
